// ===== hw/rtl/rsq_pkg.sv =====
// Shared constants, types and tables of the prefix rotate/scale query block.
package rsq_pkg;

  localparam int MAX_OPS = 4096;
  localparam int CORDIC_STEPS = 24;
  localparam int DEPTH = MAX_OPS + 1;
  localparam int CNT_W = $clog2(MAX_OPS + 1);
  localparam int ADDR_W = CNT_W;
  localparam int STEP_W = $clog2(CORDIC_STEPS);

  localparam logic [1:0] OP_SCALE = 2'd0;
  localparam logic [1:0] OP_ROTATE = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_STORED = 3'd1;
  localparam logic [2:0] ST_BAD_RANGE = 3'd2;
  localparam logic [2:0] ST_FULL = 3'd3;
  localparam logic [2:0] ST_ZERO_SCALE = 3'd4;

  localparam logic [31:0] ONE_MANT = 32'h8000_0000;
  localparam logic [31:0] RAD_TO_TURN = 32'd1367130551;
  localparam logic [31:0] INV_GAIN = 32'd2608131496;
  localparam logic signed [21:0] EXP_MAX = 22'sd524287;
  localparam logic signed [21:0] EXP_MIN = -22'sd524288;

  typedef struct packed {
    logic signed [19:0] ex;
    logic [31:0] mant;
  } scale_t;

  typedef struct packed {
    logic en;
    logic [ADDR_W-1:0] addr;
    scale_t scale;
    logic [31:0] turn;
  } mem_wr_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] t;
    case (i)
      5'd0: t = 32'd536870912;
      5'd1: t = 32'd316933406;
      5'd2: t = 32'd167458907;
      5'd3: t = 32'd85004756;
      5'd4: t = 32'd42667331;
      5'd5: t = 32'd21354465;
      5'd6: t = 32'd10679838;
      5'd7: t = 32'd5340245;
      5'd8: t = 32'd2670163;
      5'd9: t = 32'd1335087;
      5'd10: t = 32'd667544;
      5'd11: t = 32'd333772;
      5'd12: t = 32'd166886;
      5'd13: t = 32'd83443;
      5'd14: t = 32'd41722;
      5'd15: t = 32'd20861;
      5'd16: t = 32'd10430;
      5'd17: t = 32'd5215;
      5'd18: t = 32'd2608;
      5'd19: t = 32'd1304;
      5'd20: t = 32'd652;
      5'd21: t = 32'd326;
      5'd22: t = 32'd163;
      5'd23: t = 32'd81;
      5'd24: t = 32'd41;
      5'd25: t = 32'd20;
      5'd26: t = 32'd10;
      5'd27: t = 32'd5;
      5'd28: t = 32'd3;
      5'd29: t = 32'd1;
      5'd30: t = 32'd1;
      default: t = 32'd0;
    endcase
    return t;
  endfunction

endpackage

// ===== hw/rtl/rsq_mem.sv =====
// Prefix tables of scale and turn, one write port and one registered read port.
module rsq_mem (
  input  logic                          clk,
  input  rsq_pkg::mem_wr_t              wr,
  input  logic [rsq_pkg::ADDR_W-1:0]    rd_addr,
  output rsq_pkg::scale_t               rd_scale,
  output logic [31:0]                   rd_turn
);

  rsq_pkg::scale_t scale_mem [rsq_pkg::DEPTH];
  logic [31:0] turn_mem [rsq_pkg::DEPTH];
  rsq_pkg::scale_t scale_q;
  logic [31:0] turn_q;
  logic rd_zero;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      scale_mem[wr.addr] <= wr.scale;
      turn_mem[wr.addr] <= wr.turn;
    end
    scale_q <= scale_mem[rd_addr];
    turn_q <= turn_mem[rd_addr];
    rd_zero <= (rd_addr == '0);
  end

  // Entry zero is never written and always reads as the identity.
  always_comb begin
    if (rd_zero) begin
      rd_scale.ex = '0;
      rd_scale.mant = rsq_pkg::ONE_MANT;
      rd_turn = '0;
    end else begin
      rd_scale = scale_q;
      rd_turn = turn_q;
    end
  end

endmodule

// ===== hw/rtl/rsq_div.sv =====
// Restoring divider for the mantissa ratio, one quotient bit per cycle.
module rsq_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [31:0] quo
);

  logic        run;
  logic [31:0] rem;
  logic [31:0] dreg;
  logic        ib;
  logic [4:0]  cnt;
  logic [32:0] r2;
  logic        ge;

  assign r2 = {rem, ib};
  assign ge = (r2 >= {1'b0, dreg});

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        rem <= {1'b0, num[31:1]};
        ib <= num[0];
        dreg <= den;
        cnt <= '0;
        quo <= '0;
      end else if (run) begin
        rem <= ge ? 32'(r2 - {1'b0, dreg}) : r2[31:0];
        quo <= {quo[30:0], ge};
        ib <= 1'b0;
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/rsq_cordic.sv =====
// Iterative CORDIC rotation, one micro-rotation per cycle.
module rsq_cordic (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] x0,
  input  logic [63:0] y0,
  input  logic [31:0] z0,
  output logic        done,
  output logic [63:0] x,
  output logic [63:0] y
);

  localparam logic [rsq_pkg::STEP_W-1:0] LAST = rsq_pkg::STEP_W'(rsq_pkg::CORDIC_STEPS - 1);

  logic                      run;
  logic [31:0]               z;
  logic [rsq_pkg::STEP_W-1:0] cnt;
  logic [4:0]                sh;
  logic [63:0]               dx;
  logic [63:0]               dy;
  logic [31:0]               zp;
  logic [31:0]               at;

  assign sh = 5'(cnt);
  assign dx = $unsigned($signed(y) >>> sh);
  assign dy = $unsigned($signed(x) >>> sh);
  assign zp = z0 + 32'h4000_0000;
  assign at = rsq_pkg::atan_turn(sh);

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
        if (zp[31]) begin
          x <= 64'd0 - x0;
          y <= 64'd0 - y0;
          z <= z0 + 32'h8000_0000;
        end else begin
          x <= x0;
          y <= y0;
          z <= z0;
        end
      end else if (run) begin
        if (z[31]) begin
          x <= x + dx;
          y <= y - dy;
          z <= z + at;
        end else begin
          x <= x - dx;
          y <= y + dy;
          z <= z - at;
        end
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/rsq_fin.sv =====
// Three-stage pipeline that scales a coordinate, shifts, rounds and saturates.
module rsq_fin (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [63:0]        r,
  input  logic [31:0]        g,
  input  logic signed [21:0] s,
  output logic               out_valid,
  output logic [63:0]        res
);

  logic        v1, v2;
  logic        neg1, neg2;
  logic [63:0] a1, b1;
  logic signed [21:0] s1;
  logic [62:0] m2;
  logic        cap2, rb2;
  logic [63:0] mag;
  logic [63:0] hi;
  logic [95:0] val;
  logic [21:0] kneg;
  logic [158:0] wide;
  logic [95:0] tsh;
  logic [62:0] m_c;
  logic        cap_c, rb_c;
  logic [63:0] sum;
  logic        capf;

  assign mag = r[63] ? (64'd0 - r) : r;
  assign hi = a1 + {32'd0, b1[63:32]};
  assign val = {hi, b1[31:0]};
  assign kneg = 22'(-s1);
  assign wide = {63'd0, val} << kneg[5:0];
  assign tsh = val >> 7'(s1 - 22'sd1);

  always_comb begin
    m_c = '0;
    cap_c = 1'b0;
    rb_c = 1'b0;
    if (s1 <= 22'sd0) begin
      if (kneg > 22'd62) begin
        cap_c = |val;
      end else begin
        cap_c = |wide[158:63];
        m_c = wide[62:0];
      end
    end else if (s1 <= 22'sd96) begin
      cap_c = |tsh[95:64];
      m_c = tsh[63:1];
      rb_c = tsh[0];
    end
  end

  assign sum = {1'b0, m2} + {63'd0, rb2};
  assign capf = cap2 | sum[63];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
    neg1 <= r[63];
    a1 <= {32'd0, mag[63:32]} * {32'd0, g};
    b1 <= {32'd0, mag[31:0]} * {32'd0, g};
    s1 <= s;
    neg2 <= neg1;
    m2 <= m_c;
    cap2 <= cap_c;
    rb2 <= rb_c;
    if (neg2) begin
      res <= capf ? 64'h8000_0000_0000_0000 : (64'd0 - sum);
    end else begin
      res <= capf ? 64'h7FFF_FFFF_FFFF_FFFF : sum;
    end
  end

endmodule

// ===== hw/rtl/prefix_rotate_scale_query.sv =====
// Top level of the prefix rotate/scale query block.
//
// One command channel: a transaction is accepted at a rising edge with start
// high and busy low. Every transaction returns exactly one result on
// result_x, result_y and status, shown for one cycle while done is high.
// The receiver cannot stall; it must take the result in that cycle.
// Rejected commands (zero scale, full table, bad range or bad op) answer in
// the cycle after acceptance and leave busy low.
// A scale append shifts the factor in the one-bit-per-cycle normalizer, one step
// per leading zero, then uses the shared multiplier and rounds and stores.
// A rotate append uses the shared multiplier, then rounds and stores.
// A query passes through two memory reads, the restoring divider, the gain
// multiply, one CORDIC step per cycle and the three-stage output pipeline.
// One command is processed at a time.
// Reset clears the operation count and the cached last prefix entry; the
// prefix memories need no clearing pass because only written entries are
// ever read.
module prefix_rotate_scale_query (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         op,
  input  logic [31:0]        scale_factor,
  input  logic signed [31:0] angle,
  input  logic [12:0]        first_index,
  input  logic [12:0]        last_index,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  output logic               done,
  output logic signed [63:0] result_x,
  output logic signed [63:0] result_y,
  output logic [2:0]         status
);

  typedef enum logic [3:0] {
    S_IDLE, S_NORM, S_SMUL, S_SRND, S_RMUL, S_RRND, S_QRDB, S_QRDA,
    S_QCAP, S_DIV, S_GMUL, S_GRND, S_CORD, S_FINX, S_FINY, S_FWAIT
  } state_t;

  state_t state;
  logic [rsq_pkg::CNT_W-1:0] op_count;
  rsq_pkg::scale_t last_scale;
  logic [31:0] last_turn;
  logic [31:0] kreg;
  logic [4:0]  lz;
  logic [31:0] opa, opb;
  logic [63:0] prod;
  logic        rneg;
  logic [rsq_pkg::ADDR_W-1:0] qa, qb;
  logic signed [31:0] px, py;
  rsq_pkg::scale_t sj;
  logic [31:0] tj, tz;
  logic signed [21:0] s_reg;
  logic [31:0] g_reg;
  logic        got_x;

  rsq_pkg::mem_wr_t wr;
  logic [rsq_pkg::ADDR_W-1:0] rd_addr;
  rsq_pkg::scale_t rd_scale;
  logic [31:0] rd_turn;

  logic        div_start, div_done;
  logic [31:0] div_den, quo;
  logic        cor_start, cor_done;
  logic [63:0] cx, cy;
  logic        fin_valid, fin_ovalid;
  logic [63:0] fin_r, fin_res;

  logic        full;
  logic        bad_range;
  logic signed [21:0] e_base, e1, e2;
  logic [64:0] rnd_a;
  logic [32:0] m33;
  logic [31:0] m_new;
  logic signed [19:0] e_sat;
  logic [64:0] trnd;
  logic [31:0] turn_add;
  logic [31:0] mag_in;

  assign busy = (state != S_IDLE);
  assign full = (32'(op_count) >= rsq_pkg::MAX_OPS);
  assign bad_range = (first_index == 13'd0) || (32'(last_index) > 32'(op_count)) ||
                     (32'(first_index) > 32'(last_index) + 32'd1);
  assign mag_in = angle[31] ? (32'd0 - angle) : angle;

  always_comb begin
    e_base = 22'(last_scale.ex) + 22'sd1 - $signed({17'd0, lz});
    if (prod[63]) begin
      rnd_a = {1'b0, prod} + 65'h0_8000_0000;
      m33 = rnd_a[64:32];
      e1 = e_base + 22'sd1;
    end else begin
      rnd_a = {1'b0, prod} + 65'h0_4000_0000;
      m33 = rnd_a[63:31];
      e1 = e_base;
    end
    if (m33[32]) begin
      m_new = rsq_pkg::ONE_MANT;
      e2 = e1 + 22'sd1;
    end else begin
      m_new = m33[31:0];
      e2 = e1;
    end
    if (e2 > rsq_pkg::EXP_MAX) begin
      e_sat = 20'(rsq_pkg::EXP_MAX);
    end else if (e2 < rsq_pkg::EXP_MIN) begin
      e_sat = 20'(rsq_pkg::EXP_MIN);
    end else begin
      e_sat = 20'(e2);
    end
    trnd = {1'b0, prod} + 65'h1000_0000;
    turn_add = rneg ? (32'd0 - trnd[60:29]) : trnd[60:29];
  end

  always_comb begin
    wr.en = 1'b0;
    wr.addr = rsq_pkg::ADDR_W'(32'(op_count) + 32'd1);
    wr.scale = last_scale;
    wr.turn = last_turn;
    if (state == S_SRND) begin
      wr.en = 1'b1;
      wr.scale.mant = m_new;
      wr.scale.ex = e_sat;
    end else if (state == S_RRND) begin
      wr.en = 1'b1;
      wr.turn = last_turn + turn_add;
    end
    rd_addr = (state == S_QRDB) ? qb : qa;
    div_start = (state == S_QCAP);
    div_den = (rd_scale.mant == 32'd0) ? rsq_pkg::ONE_MANT : rd_scale.mant;
    cor_start = (state == S_GRND);
    fin_valid = (state == S_FINX) || (state == S_FINY);
    fin_r = (state == S_FINX) ? cx : cy;
  end

  rsq_mem u_mem (
    .clk      (clk),
    .wr       (wr),
    .rd_addr  (rd_addr),
    .rd_scale (rd_scale),
    .rd_turn  (rd_turn)
  );

  rsq_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (sj.mant),
    .den   (div_den),
    .done  (div_done),
    .quo   (quo)
  );

  rsq_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .x0    ({{3{px[31]}}, px, 29'd0}),
    .y0    ({{3{py[31]}}, py, 29'd0}),
    .z0    (tz),
    .done  (cor_done),
    .x     (cx),
    .y     (cy)
  );

  rsq_fin u_fin (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fin_valid),
    .r         (fin_r),
    .g         (g_reg),
    .s         (s_reg),
    .out_valid (fin_ovalid),
    .res       (fin_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op_count <= '0;
      last_scale.ex <= '0;
      last_scale.mant <= rsq_pkg::ONE_MANT;
      last_turn <= '0;
      done <= 1'b0;
      got_x <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            result_x <= '0;
            result_y <= '0;
            if (op == rsq_pkg::OP_SCALE) begin
              if (scale_factor == 32'd0) begin
                status <= rsq_pkg::ST_ZERO_SCALE;
                done <= 1'b1;
              end else if (full) begin
                status <= rsq_pkg::ST_FULL;
                done <= 1'b1;
              end else begin
                kreg <= scale_factor;
                lz <= '0;
                state <= S_NORM;
              end
            end else if (op == rsq_pkg::OP_ROTATE) begin
              if (full) begin
                status <= rsq_pkg::ST_FULL;
                done <= 1'b1;
              end else begin
                rneg <= angle[31];
                opa <= mag_in;
                opb <= rsq_pkg::RAD_TO_TURN;
                state <= S_RMUL;
              end
            end else if (op == rsq_pkg::OP_QUERY) begin
              if (bad_range) begin
                status <= rsq_pkg::ST_BAD_RANGE;
                done <= 1'b1;
              end else begin
                qa <= rsq_pkg::ADDR_W'(32'(first_index) - 32'd1);
                qb <= rsq_pkg::ADDR_W'(last_index);
                px <= point_x;
                py <= point_y;
                state <= S_QRDB;
              end
            end else begin
              status <= rsq_pkg::ST_BAD_RANGE;
              done <= 1'b1;
            end
          end
        end
        S_NORM: begin
          if (kreg[31]) begin
            opa <= last_scale.mant;
            opb <= kreg;
            state <= S_SMUL;
          end else begin
            kreg <= {kreg[30:0], 1'b0};
            lz <= lz + 5'd1;
          end
        end
        S_SMUL, S_RMUL, S_GMUL: begin
          prod <= {32'd0, opa} * {32'd0, opb};
          state <= (state == S_SMUL) ? S_SRND : ((state == S_RMUL) ? S_RRND : S_GRND);
        end
        S_SRND, S_RRND: begin
          last_scale <= wr.scale;
          last_turn <= wr.turn;
          op_count <= op_count + 1'b1;
          status <= rsq_pkg::ST_STORED;
          done <= 1'b1;
          state <= S_IDLE;
        end
        S_QRDB: state <= S_QRDA;
        S_QRDA: begin
          sj <= rd_scale;
          tj <= rd_turn;
          state <= S_QCAP;
        end
        S_QCAP: begin
          tz <= tj - rd_turn;
          s_reg <= 22'sd44 - (22'(sj.ex) - 22'(rd_scale.ex));
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            opa <= quo;
            opb <= rsq_pkg::INV_GAIN;
            state <= S_GMUL;
          end
        end
        S_GRND: begin
          g_reg <= 32'(({1'b0, prod} + 65'h0_8000_0000) >> 32);
          state <= S_CORD;
        end
        S_CORD: begin
          if (cor_done) begin
            got_x <= 1'b0;
            state <= S_FINX;
          end
        end
        S_FINX: state <= S_FINY;
        S_FINY: state <= S_FWAIT;
        S_FWAIT: begin
          if (fin_ovalid) begin
            if (!got_x) begin
              result_x <= fin_res;
              got_x <= 1'b1;
            end else begin
              result_y <= fin_res;
              status <= rsq_pkg::ST_OK;
              done <= 1'b1;
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/rsq_checker.sv =====
// Port-level checker for the prefix rotate/scale query block, with its bind.
module rsq_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic signed [63:0] result_x,
  input logic signed [63:0] result_y,
  input logic [2:0]         status
);

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("Result shown while the block is still busy.");

  a_accept_answer: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("Accepted transaction neither started nor answered.");

  a_busy_ends_done: assert property (@(posedge clk) disable iff (rst) $fell(busy) |-> done)
    else $error("Busy dropped without a result.");

  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (done && status != rsq_pkg::ST_OK) |-> (result_x == 64'sd0 && result_y == 64'sd0))
    else $error("Non-query result carries nonzero coordinates.");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status <= rsq_pkg::ST_ZERO_SCALE))
    else $error("Status code out of range.");

endmodule

bind prefix_rotate_scale_query rsq_checker u_rsq_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .done     (done),
  .result_x (result_x),
  .result_y (result_y),
  .status   (status)
);

// ===== tb/prefix_rotate_scale_query_test.sv =====
// Self-checking testbench for the prefix rotate/scale query block with its own prediction.
module prefix_rotate_scale_query_test;

  localparam logic [1:0] OP_INVALID = 2'd3;
  localparam logic [63:0] SAT_LIMIT = 64'h8000_0000_0000_0000;
  localparam int RANDOM_ITEMS = 420;
  localparam int TAIL_ITEMS = 80;

  typedef struct {
    logic [1:0] op;
    logic [31:0] factor;
    logic [31:0] ang;
    logic [12:0] first;
    logic [12:0] last;
    logic [31:0] px;
    logic [31:0] py;
  } command_t;

  typedef struct {
    logic [63:0] rx;
    logic [63:0] ry;
    logic [2:0] st;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] op = rsq_pkg::OP_SCALE;
  logic [31:0] scale_factor = '0;
  logic signed [31:0] angle = '0;
  logic [12:0] first_index = '0;
  logic [12:0] last_index = '0;
  logic signed [31:0] point_x = '0;
  logic signed [31:0] point_y = '0;
  logic done;
  logic signed [63:0] result_x;
  logic signed [63:0] result_y;
  logic [2:0] status;

  command_t cmd_queue[$];
  answer_t answers_due[$];
  command_t cur_cmd;
  int idle_left = 0;
  int errors = 0;
  int gen_count = 0;

  logic [51:0] scale_tab[0:rsq_pkg::MAX_OPS];
  logic [31:0] turn_tab[0:rsq_pkg::MAX_OPS];
  int stored_ops = 0;

  prefix_rotate_scale_query dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .scale_factor(scale_factor), .angle(angle), .first_index(first_index),
    .last_index(last_index), .point_x(point_x), .point_y(point_y),
    .done(done), .result_x(result_x), .result_y(result_y), .status(status)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [63:0] round_shift(logic [63:0] hi, logic [63:0] lo, int s);
    logic [63:0] v;
    int t;
    if (s <= 0) begin
      if ((hi >> 31) != 0) return SAT_LIMIT;
      v = (hi << 32) | lo;
      if (v == 0) return 0;
      if (-s >= 63 || v > (SAT_LIMIT >> -s)) return SAT_LIMIT;
      return v << -s;
    end
    if (s < 32) begin
      if ((hi >> (31 + s)) != 0) return SAT_LIMIT;
      return ((hi << (32 - s)) | (lo >> s)) + ((lo >> (s - 1)) & 64'd1);
    end
    t = s - 32;
    if (t == 0) return hi + (lo >> 31);
    if (t <= 63) return (hi >> t) + ((hi >> (t - 1)) & 64'd1);
    return 0;
  endfunction

  function automatic logic [63:0] scale_coord(logic [63:0] r, logic [31:0] g, int s);
    logic [63:0] mag, a, b, m;
    mag = r[63] ? -r : r;
    a = (mag >> 32) * {32'd0, g};
    b = (mag & 64'hFFFF_FFFF) * {32'd0, g};
    m = round_shift(a + (b >> 32), b & 64'hFFFF_FFFF, s);
    if (r[63]) return (m >= SAT_LIMIT) ? SAT_LIMIT : -m;
    return (m >= SAT_LIMIT) ? SAT_LIMIT - 1 : m;
  endfunction

  function automatic answer_t compute_answer(command_t c);
    answer_t ans;
    logic [51:0] prev;
    logic [31:0] mk, z, g32;
    logic [64:0] prod, m;
    logic [63:0] mj, mi, q, x, y, dx, dy, mag;
    logic [127:0] wide;
    int e, p, s;
    ans = '{64'd0, 64'd0, rsq_pkg::ST_STORED};
    if (c.op == rsq_pkg::OP_SCALE || c.op == rsq_pkg::OP_ROTATE) begin
      if (c.op == rsq_pkg::OP_SCALE && c.factor == 0) begin
        ans.st = rsq_pkg::ST_ZERO_SCALE;
      end else if (stored_ops >= rsq_pkg::MAX_OPS) begin
        ans.st = rsq_pkg::ST_FULL;
      end else begin
        prev = scale_tab[stored_ops];
        z = 0;
        if (c.op == rsq_pkg::OP_SCALE) begin
          p = 31;
          while (!c.factor[p]) p--;
          mk = c.factor << (31 - p);
          e = $signed(prev[51:32]) + p - 30;
          prod = {33'd0, prev[31:0]} * {33'd0, mk};
          if (prod[63]) begin
            m = (prod + 65'h8000_0000) >> 32;
            e++;
          end else begin
            m = (prod + 65'h4000_0000) >> 31;
          end
          if ((m >> 32) != 0) begin
            m = {33'd0, rsq_pkg::ONE_MANT};
            e++;
          end
          if (e > rsq_pkg::EXP_MAX) e = rsq_pkg::EXP_MAX;
          if (e < rsq_pkg::EXP_MIN) e = rsq_pkg::EXP_MIN;
          prev = {e[19:0], m[31:0]};
        end else begin
          mag = c.ang[31] ? 64'h1_0000_0000 - {32'd0, c.ang} : {32'd0, c.ang};
          q = (mag * {32'd0, rsq_pkg::RAD_TO_TURN} + 64'h1000_0000) >> 29;
          z = c.ang[31] ? -q[31:0] : q[31:0];
        end
        scale_tab[stored_ops + 1] = prev;
        turn_tab[stored_ops + 1] = turn_tab[stored_ops] + z;
        stored_ops++;
      end
    end else if (c.op == rsq_pkg::OP_QUERY) begin
      if (c.first == 0 || c.last > stored_ops || c.first > c.last + 1) begin
        ans.st = rsq_pkg::ST_BAD_RANGE;
      end else begin
        mj = {32'd0, scale_tab[c.last][31:0]};
        mi = {32'd0, scale_tab[c.first - 1][31:0]};
        if (mi == 0) mi = {32'd0, rsq_pkg::ONE_MANT};
        q = (mj << 31) / mi;
        wide = {64'd0, q} * {96'd0, rsq_pkg::INV_GAIN} + 128'h8000_0000;
        g32 = wide[63:32];
        s = 44 - ($signed(scale_tab[c.last][51:32]) -
                  $signed(scale_tab[c.first - 1][51:32]));
        z = turn_tab[c.last] - turn_tab[c.first - 1];
        x = {{32{c.px[31]}}, c.px} << 29;
        y = {{32{c.py[31]}}, c.py} << 29;
        if (((z + 32'h4000_0000) & 32'h8000_0000) != 0) begin
          x = -x;
          y = -y;
          z = z + 32'h8000_0000;
        end
        for (int i = 0; i < rsq_pkg::CORDIC_STEPS; i++) begin
          dx = $signed(y) >>> (i & 31);
          dy = $signed(x) >>> (i & 31);
          if (z[31]) begin
            x = x + dx;
            y = y - dy;
            z = z + rsq_pkg::atan_turn(i[4:0]);
          end else begin
            x = x - dx;
            y = y + dy;
            z = z - rsq_pkg::atan_turn(i[4:0]);
          end
        end
        ans = '{scale_coord(x, g32, s), scale_coord(y, g32, s), rsq_pkg::ST_OK};
      end
    end else begin
      ans.st = rsq_pkg::ST_BAD_RANGE;
    end
    return ans;
  endfunction

  task automatic add_cmd(logic [1:0] o, logic [31:0] k, logic [31:0] a, int f, int l,
                         logic [31:0] x, logic [31:0] y);
    command_t c;
    c = '{o, k, a, f[12:0], l[12:0], x, y};
    if ((o == rsq_pkg::OP_SCALE && k != 0 || o == rsq_pkg::OP_ROTATE) &&
        gen_count < rsq_pkg::MAX_OPS) gen_count++;
    cmd_queue.push_back(c);
  endtask

  function automatic logic [31:0] rand_factor();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(1, 255);
      2: return 32'd1 << $urandom_range(0, 31);
      default: return 32'h3000_0000 + $urandom_range(0, 32'h2000_0000);
    endcase
  endfunction

  function automatic logic [31:0] rand_coord();
    if ($urandom_range(0, 1)) return $urandom();
    return $urandom_range(0, 2000) - 1000;
  endfunction

  task automatic add_random_cmd();
    int f, l;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5: add_cmd(rsq_pkg::OP_SCALE, rand_factor(), 0, 0, 0, 0, 0);
      6, 7, 8, 9, 10: add_cmd(rsq_pkg::OP_ROTATE, 0, $urandom(), 0, 0, 0, 0);
      11: add_cmd(OP_INVALID, $urandom(), $urandom(), $urandom(), $urandom(),
                  $urandom(), $urandom());
      12: add_cmd(rsq_pkg::OP_QUERY, 0, 0, $urandom_range(0, 8191),
                  $urandom_range(0, 8191), rand_coord(), rand_coord());
      default: begin
        l = $urandom_range(0, gen_count);
        f = $urandom_range(1, l + 1);
        add_cmd(rsq_pkg::OP_QUERY, $urandom(), $urandom(), f, l, rand_coord(),
                rand_coord());
      end
    endcase
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
  endtask

  always @(posedge clk) begin
    logic next_start;
    if (!rst) begin
      next_start = start;
      if (start && !busy) begin
        answers_due.push_back(compute_answer(cur_cmd));
        next_start = 1'b0;
      end
      if (!next_start) begin
        if (idle_left > 0) begin
          idle_left--;
        end else if (cmd_queue.size() > 0) begin
          if (cmd_queue.size() > TAIL_ITEMS && $urandom_range(0, 3) == 0) begin
            idle_left = $urandom_range(1, 13);
          end else begin
            cur_cmd = cmd_queue.pop_front();
            op <= cur_cmd.op;
            scale_factor <= cur_cmd.factor;
            angle <= cur_cmd.ang;
            first_index <= cur_cmd.first;
            last_index <= cur_cmd.last;
            point_x <= cur_cmd.px;
            point_y <= cur_cmd.py;
            next_start = 1'b1;
          end
        end
      end
      start <= next_start;
    end
  end

  always @(posedge clk) begin
    answer_t want;
    if (!rst && done) begin
      if (answers_due.size() == 0) begin
        report("unexpected result", {61'd0, status}, 64'd0);
      end else begin
        want = answers_due.pop_front();
        if (status !== want.st) report("status", {61'd0, status}, {61'd0, want.st});
        if (result_x !== want.rx) report("result_x", result_x, want.rx);
        if (result_y !== want.ry) report("result_y", result_y, want.ry);
      end
    end
  end

  initial begin
    scale_tab[0] = {20'd0, rsq_pkg::ONE_MANT};
    turn_tab[0] = '0;
    add_cmd(rsq_pkg::OP_QUERY, 0, 0, 1, 0, 32'h7FFF_FFFF, 32'h8000_0000);
    add_cmd(rsq_pkg::OP_QUERY, 0, 0, 0, 0, 1, 1);
    add_cmd(rsq_pkg::OP_QUERY, 0, 0, 1, 1, 1, 1);
    add_cmd(OP_INVALID, 5, 5, 1, 1, 1, 1);
    add_cmd(rsq_pkg::OP_SCALE, 0, 0, 0, 0, 0, 0);
    add_cmd(rsq_pkg::OP_SCALE, 32'hFFFF_FFFF, 0, 0, 0, 0, 0);
    add_cmd(rsq_pkg::OP_SCALE, 32'd1, 0, 0, 0, 0, 0);
    add_cmd(rsq_pkg::OP_SCALE, 32'h4000_0000, 0, 0, 0, 0, 0);
    add_cmd(rsq_pkg::OP_ROTATE, 0, 32'h7FFF_FFFF, 0, 0, 0, 0);
    add_cmd(rsq_pkg::OP_ROTATE, 0, 32'h8000_0000, 0, 0, 0, 0);
    add_cmd(rsq_pkg::OP_ROTATE, 0, 32'd0, 0, 0, 0, 0);
    add_cmd(rsq_pkg::OP_SCALE, 32'hFFFF_FFFF, 0, 0, 0, 0, 0);
    add_cmd(rsq_pkg::OP_QUERY, 0, 0, 1, 7, 32'h8000_0000, 32'h8000_0000);
    add_cmd(rsq_pkg::OP_QUERY, 0, 0, 1, 7, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_cmd(rsq_pkg::OP_QUERY, 0, 0, 2, 2, 32'h7FFF_FFFF, 32'h8000_0000);
    add_cmd(rsq_pkg::OP_QUERY, 0, 0, 3, 6, 0, 0);
    add_cmd(rsq_pkg::OP_QUERY, 0, 0, 5, 6, 1000, -1000);
    add_cmd(rsq_pkg::OP_QUERY, 0, 0, 3, 1, 1, 1);
    add_cmd(rsq_pkg::OP_QUERY, 0, 0, 3, 2, -7, 9);
    add_cmd(rsq_pkg::OP_QUERY, 0, 0, 1, 8, 1, 1);
    for (int i = 0; i < RANDOM_ITEMS; i++) add_random_cmd();
    add_cmd(rsq_pkg::OP_SCALE, rand_factor(), 0, 0, 0, 0, 0);
    add_cmd(rsq_pkg::OP_ROTATE, 0, $urandom(), 0, 0, 0, 0);
    add_cmd(rsq_pkg::OP_SCALE, 0, 0, 0, 0, 0, 0);
    add_cmd(rsq_pkg::OP_QUERY, 0, 0, 1, rsq_pkg::MAX_OPS, 32'h7FFF_FFFF, 32'h8000_0000);
    add_cmd(rsq_pkg::OP_QUERY, 0, 0, rsq_pkg::MAX_OPS + 1, rsq_pkg::MAX_OPS, 123, -456);
    add_cmd(rsq_pkg::OP_QUERY, 0, 0, rsq_pkg::MAX_OPS, rsq_pkg::MAX_OPS, rand_coord(),
            rand_coord());
    add_cmd(rsq_pkg::OP_QUERY, 0, 0, 1, rsq_pkg::MAX_OPS + 1, 1, 1);
    for (int i = 0; i < 60; i++) add_random_cmd();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    wait (cmd_queue.size() == 0 && !start && answers_due.size() == 0);
    repeat (150) @(posedge clk);
    if (errors == 0 && answers_due.size() == 0) begin
      $display("** prefix_rotate_scale_query: PASSED **");
    end else begin
      $display("** prefix_rotate_scale_query: FAILED **");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("** prefix_rotate_scale_query: FAILED **");
    $finish;
  end

endmodule
